// ===== design/stsab_pkg.sv =====
`timescale 1ns / 1ps

package stsab_pkg;

    // Fixed widths of the channel fields
    localparam int PIXEL_W     = 12;
    localparam int TEXEL_IDX_W = 6;
    localparam int WORD_W      = 32;
    localparam int SIZE_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int SUM_W       = 16;

    // Default sizes for the top level
    localparam int TEX_DIM_LOG2_DEF = 6;
    localparam int COORD_BITS_DEF   = 12;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SHADE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_U_BASE     = 3'd0,
        REG_U_STEP     = 3'd1,
        REG_V_BASE     = 3'd2,
        REG_V_STEP     = 3'd3,
        REG_TEX_WIDTH  = 3'd4,
        REG_TEX_HEIGHT = 3'd5
    } cfg_reg_t;

    // Weighted sum of one channel: s*a + d*(255-a), at most 255*255
    function automatic logic [SUM_W-1:0] blend_sum(
        input logic [7:0] s,
        input logic [7:0] d,
        input logic [7:0] a
    );
        logic [7:0] inv_a;
        inv_a = 8'd255 - a;
        return SUM_W'(s) * SUM_W'(a) + SUM_W'(d) * SUM_W'(inv_a);
    endfunction

    // Truncating divide by 255, exact for 0 .. 255*255
    function automatic logic [7:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = (SUM_W+1)'(x) + (SUM_W+1)'(1) + (SUM_W+1)'(x >> 8);
        return t[15:8];
    endfunction

endpackage

// ===== design/sprite_texel_sample_alpha_blend.sv =====
`timescale 1ns / 1ps

// Sprite blitter pixel stage: nearest texel lookup with alpha blend.
// Input channel (in_valid / in_ready): op 0 loads texel_value into the
// texture memory at (texel_row, texel_col); op 1 shades one destination
// pixel at (pixel_x, pixel_y) over its current value dest_pixel.
// Output channel (out_valid / out_ready): one out_pixel per shade op,
// in order; a load produces no transfer.
// Configuration: cfg_we writes cfg_data into register cfg_index (u_base,
// u_step, v_base, v_step, tex_width, tex_height); write only while idle.
// Pipeline: five register stages (step multiply, add and clamp, texture
// read, channel multiply, divide by 255). Throughput is one item per
// cycle while no result waits for the receiver.
// A stalled receiver freezes the whole pipe: in_ready drops while an
// unaccepted result sits in the output register, and no item is lost.
// Reset clears the valid bits and the configuration registers (sizes
// to 1). The texture memory is not cleared: load every texel before use.
module sprite_texel_sample_alpha_blend #(
    parameter int TEX_DIM_LOG2 = stsab_pkg::TEX_DIM_LOG2_DEF,
    parameter int COORD_BITS   = stsab_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [stsab_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stsab_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [stsab_pkg::PIXEL_W-1:0]        pixel_x,
    input  logic [stsab_pkg::PIXEL_W-1:0]        pixel_y,
    input  logic [stsab_pkg::WORD_W-1:0]         dest_pixel,
    input  logic [stsab_pkg::TEXEL_IDX_W-1:0]    texel_col,
    input  logic [stsab_pkg::TEXEL_IDX_W-1:0]    texel_row,
    input  logic [stsab_pkg::WORD_W-1:0]         texel_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [stsab_pkg::WORD_W-1:0]         out_pixel
);

    localparam int IW        = TEX_DIM_LOG2;
    localparam int TEX_DIM   = 1 << TEX_DIM_LOG2;
    localparam int ADDR_W    = 2 * TEX_DIM_LOG2;
    localparam int TEX_WORDS = 1 << ADDR_W;
    localparam int CW        = (COORD_BITS < stsab_pkg::PIXEL_W) ?
                               COORD_BITS : stsab_pkg::PIXEL_W;
    localparam int TCW       = (TEX_DIM_LOG2 < stsab_pkg::TEXEL_IDX_W) ?
                               TEX_DIM_LOG2 : stsab_pkg::TEXEL_IDX_W;
    localparam int PROD_W    = CW + 33;
    localparam int POS_W     = PROD_W + 1;
    localparam int IDX_W     = POS_W - 16;
    localparam int LIM_W     = (TEX_DIM_LOG2 + 1 > stsab_pkg::SIZE_W) ?
                               TEX_DIM_LOG2 + 1 : stsab_pkg::SIZE_W;

    // Configuration registers
    logic [31:0]                   u_base_reg, u_step_reg, v_base_reg, v_step_reg;
    logic [stsab_pkg::SIZE_W-1:0]  tex_width_reg, tex_height_reg;

    // Pipeline stage registers
    logic                     s1_valid_reg, s1_op_reg;
    logic signed [PROD_W-1:0] s1_u_prod_reg, s1_v_prod_reg;
    logic [IW-1:0]            s1_col_reg, s1_row_reg;
    logic [31:0]              s1_data_reg;

    logic                     s2_valid_reg, s2_op_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;
    logic [31:0]              s2_data_reg;

    logic                     s3_valid_reg;
    logic [31:0]              s3_texel_reg, s3_dest_reg;

    logic                     s4_valid_reg;
    logic [stsab_pkg::SUM_W-1:0] s4_b_reg, s4_g_reg, s4_r_reg, s4_a_reg;

    logic                     out_valid_reg;
    logic [31:0]              out_pixel_reg;

    logic [31:0]              tex_mem [TEX_WORDS];

    logic                     advance;
    logic signed [PROD_W-1:0] u_prod, v_prod;
    logic signed [POS_W-1:0]  u_pos, v_pos;
    logic [IW-1:0]            col_idx, row_idx;
    logic [ADDR_W-1:0]        s2_addr_next;

    // Floor of a Q16.16 position, clamped to 0 .. size-1; size 0 acts as 1, sizes above TEX_DIM as TEX_DIM
    function automatic logic [IW-1:0] axis_clamp(
        input logic signed [POS_W-1:0] pos,
        input logic [stsab_pkg::SIZE_W-1:0] size
    );
        logic [LIM_W-1:0] size_ext;
        logic [LIM_W-1:0] lim_m1;
        logic [IDX_W-1:0] idx;
        size_ext = LIM_W'(size);
        if (size_ext == '0)
        begin
            lim_m1 = '0;
        end
        else if (size_ext > LIM_W'(TEX_DIM))
        begin
            lim_m1 = LIM_W'(TEX_DIM - 1);
        end
        else
        begin
            lim_m1 = size_ext - LIM_W'(1);
        end
        idx = pos[POS_W-1:16];
        if (pos[POS_W-1])
        begin
            return '0;
        end
        else if (idx > IDX_W'(lim_m1))
        begin
            return IW'(lim_m1);
        end
        else
        begin
            return IW'(idx);
        end
    endfunction

    // Whole pipe moves unless a finished result waits for the receiver
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_base_reg     <= '0;
            u_step_reg     <= '0;
            v_base_reg     <= '0;
            v_step_reg     <= '0;
            tex_width_reg  <= stsab_pkg::SIZE_W'(1);
            tex_height_reg <= stsab_pkg::SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            case (stsab_pkg::cfg_reg_t'(cfg_index))
                stsab_pkg::REG_U_BASE:     u_base_reg     <= cfg_data;
                stsab_pkg::REG_U_STEP:     u_step_reg     <= cfg_data;
                stsab_pkg::REG_V_BASE:     v_base_reg     <= cfg_data;
                stsab_pkg::REG_V_STEP:     v_step_reg     <= cfg_data;
                stsab_pkg::REG_TEX_WIDTH:  tex_width_reg  <= cfg_data[stsab_pkg::SIZE_W-1:0];
                stsab_pkg::REG_TEX_HEIGHT: tex_height_reg <= cfg_data[stsab_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: coordinate times step, per axis
    assign u_prod = $signed({1'b0, pixel_x[CW-1:0]}) * $signed(u_step_reg);
    assign v_prod = $signed({1'b0, pixel_y[CW-1:0]}) * $signed(v_step_reg);

    // Stage 2: add base, clamp, form texture address
    assign u_pos = $signed({s1_u_prod_reg[PROD_W-1], s1_u_prod_reg})
                 + $signed({{(POS_W-32){u_base_reg[31]}}, u_base_reg});
    assign v_pos = $signed({s1_v_prod_reg[PROD_W-1], s1_v_prod_reg})
                 + $signed({{(POS_W-32){v_base_reg[31]}}, v_base_reg});
    assign col_idx = axis_clamp(u_pos, tex_width_reg);
    assign row_idx = axis_clamp(v_pos, tex_height_reg);

    always_comb
    begin
        if (s1_op_reg == stsab_pkg::OP_LOAD)
        begin
            s2_addr_next = {s1_row_reg, s1_col_reg};
        end
        else
        begin
            s2_addr_next = {row_idx, col_idx};
        end
    end

    // Advance valid bits; only shade ops live past the memory stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && (s2_op_reg == stsab_pkg::OP_SHADE);
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg     <= op;
            s1_u_prod_reg <= u_prod;
            s1_v_prod_reg <= v_prod;
            s1_col_reg    <= IW'(texel_col[TCW-1:0]);
            s1_row_reg    <= IW'(texel_row[TCW-1:0]);
            s1_data_reg   <= (op == stsab_pkg::OP_LOAD) ? texel_value : dest_pixel;

            s2_op_reg     <= s1_op_reg;
            s2_addr_reg   <= s2_addr_next;
            s2_data_reg   <= s1_data_reg;

            s3_dest_reg   <= s2_data_reg;

            // texel bytes R,G,B,A; destination bytes B,G,R,A
            s4_b_reg <= stsab_pkg::blend_sum(s3_texel_reg[23:16], s3_dest_reg[7:0],
                                             s3_texel_reg[31:24]);
            s4_g_reg <= stsab_pkg::blend_sum(s3_texel_reg[15:8], s3_dest_reg[15:8],
                                             s3_texel_reg[31:24]);
            s4_r_reg <= stsab_pkg::blend_sum(s3_texel_reg[7:0], s3_dest_reg[23:16],
                                             s3_texel_reg[31:24]);
            s4_a_reg <= stsab_pkg::blend_sum(s3_texel_reg[31:24], s3_dest_reg[31:24],
                                             s3_texel_reg[31:24]);

            out_pixel_reg <= {stsab_pkg::div255(s4_a_reg), stsab_pkg::div255(s4_r_reg),
                              stsab_pkg::div255(s4_g_reg), stsab_pkg::div255(s4_b_reg)};
        end
    end

    // Stage 3: texture memory, loads and reads kept in item order
    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            if (s2_op_reg == stsab_pkg::OP_LOAD)
            begin
                tex_mem[s2_addr_reg] <= s2_data_reg;
            end
            else
            begin
                s3_texel_reg <= tex_mem[s2_addr_reg];
            end
        end
    end

endmodule

// ===== verif/sprite_texel_sample_alpha_blend_checker.sv =====
`timescale 1ns / 1ps

module sprite_texel_sample_alpha_blend_checker #(
    parameter int TEX_DIM_LOG2 = stsab_pkg::TEX_DIM_LOG2_DEF,
    parameter int COORD_BITS   = stsab_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stsab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stsab_pkg::WORD_W-1:0]      cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              op,
    input  logic [stsab_pkg::PIXEL_W-1:0]     pixel_x,
    input  logic [stsab_pkg::PIXEL_W-1:0]     pixel_y,
    input  logic [stsab_pkg::WORD_W-1:0]      dest_pixel,
    input  logic [stsab_pkg::TEXEL_IDX_W-1:0] texel_col,
    input  logic [stsab_pkg::TEXEL_IDX_W-1:0] texel_row,
    input  logic [stsab_pkg::WORD_W-1:0]      texel_value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [stsab_pkg::WORD_W-1:0]      out_pixel,
    output int                                mismatches,
    output int                                pending
);
    import stsab_pkg::*;

    localparam int TEX_DIM   = 1 << TEX_DIM_LOG2;
    localparam int TEX_WORDS = 1 << (2 * TEX_DIM_LOG2);

    // Shadow copy of the texture memory and the configuration registers
    logic [WORD_W-1:0] texels [0:TEX_WORDS-1];
    logic [WORD_W-1:0] u_base_q;
    logic [WORD_W-1:0] u_step_q;
    logic [WORD_W-1:0] v_base_q;
    logic [WORD_W-1:0] v_step_q;
    logic [SIZE_W-1:0] tex_w_q;
    logic [SIZE_W-1:0] tex_h_q;

    // Shaded pixels still owed by the block, oldest first
    logic [WORD_W-1:0] owed_pixels [$];

    // Nearest texel along one axis: floor of the Q16.16 position, clamped to the size
    function automatic int nearest_texel(
        input logic [WORD_W-1:0]  base,
        input logic [WORD_W-1:0]  step,
        input logic [PIXEL_W-1:0] coord,
        input logic [SIZE_W-1:0]  size
    );
        int     lim;
        longint c;
        longint pos;
        lim = (size == 0) ? 1 : ((size > TEX_DIM) ? TEX_DIM : int'(size));
        c = longint'(coord) & ((longint'(1) << COORD_BITS) - 1);
        pos = longint'($signed(base)) + c * longint'($signed(step));
        if (pos < 0)
            return 0;
        if ((pos >>> 16) > longint'(lim - 1))
            return lim - 1;
        return int'(pos >>> 16);
    endfunction

    // Weighted channel mix, truncated
    function automatic logic [7:0] mix_channel(input int unsigned s, d, a);
        return 8'((s * a + d * (255 - a)) / 255);
    endfunction

    // Expected BGRA result for one destination pixel
    function automatic logic [WORD_W-1:0] shade_pixel(
        input logic [PIXEL_W-1:0] x,
        input logic [PIXEL_W-1:0] y,
        input logic [WORD_W-1:0]  dest
    );
        int                col;
        int                row;
        logic [WORD_W-1:0] t;
        col = nearest_texel(u_base_q, u_step_q, x, tex_w_q);
        row = nearest_texel(v_base_q, v_step_q, y, tex_h_q);
        t = texels[((row << TEX_DIM_LOG2) | col) & (TEX_WORDS - 1)];
        // Opaque texel: copy it, reordered from RGBA to BGRA
        if (t[31:24] == 8'd255)
            return {t[31:24], t[7:0], t[15:8], t[23:16]};
        return {mix_channel(t[31:24], dest[31:24], t[31:24]),
                mix_channel(t[7:0],   dest[23:16], t[31:24]),
                mix_channel(t[15:8],  dest[15:8],  t[31:24]),
                mix_channel(t[23:16], dest[7:0],   t[31:24])};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [WORD_W-1:0] want;
        int                addr;
        if (!rst_n)
        begin
            u_base_q <= '0;
            u_step_q <= '0;
            v_base_q <= '0;
            v_step_q <= '0;
            tex_w_q <= SIZE_W'(1);
            tex_h_q <= SIZE_W'(1);
            owed_pixels.delete();
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            // Compare a result transfer with the oldest owed pixel
            if (out_valid && out_ready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    $display("%0t: out_pixel %08h with no pixel owed", $time, out_pixel);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    if (out_pixel !== want)
                    begin
                        $display("%0t: out_pixel expected %08h, got %08h",
                                 $time, want, out_pixel);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            // Track register writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_U_BASE:     u_base_q <= cfg_data;
                    REG_U_STEP:     u_step_q <= cfg_data;
                    REG_V_BASE:     v_base_q <= cfg_data;
                    REG_V_STEP:     v_step_q <= cfg_data;
                    REG_TEX_WIDTH:  tex_w_q <= cfg_data[SIZE_W-1:0];
                    REG_TEX_HEIGHT: tex_h_q <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // Store a texel, or owe a shaded pixel, for each input transfer
            if (in_valid && in_ready)
            begin
                if (op == OP_LOAD)
                begin
                    addr = ((int'(texel_row) & (TEX_DIM - 1)) << TEX_DIM_LOG2)
                         | (int'(texel_col) & (TEX_DIM - 1));
                    texels[addr] <= texel_value;
                end
                else
                begin
                    want = shade_pixel(pixel_x, pixel_y, dest_pixel);
                    owed_pixels.insert(owed_pixels.size(), want);
                end
            end

            pending <= owed_pixels.size();
        end
    end

endmodule

// ===== verif/sprite_texel_sample_alpha_blend_test.sv =====
`timescale 1ns / 1ps

module sprite_texel_sample_alpha_blend_test;
    import stsab_pkg::*;

    localparam int TEX_DIM      = 1 << TEX_DIM_LOG2_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 250;
    localparam int PIXEL_MAX    = (1 << PIXEL_W) - 1;

    // Indexes past the register list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WORD_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   op;
    logic [PIXEL_W-1:0]     pixel_x;
    logic [PIXEL_W-1:0]     pixel_y;
    logic [WORD_W-1:0]      dest_pixel;
    logic [TEXEL_IDX_W-1:0] texel_col;
    logic [TEXEL_IDX_W-1:0] texel_row;
    logic [WORD_W-1:0]      texel_value;
    logic                   out_valid;
    logic                   out_ready;
    logic [WORD_W-1:0]      out_pixel;

    int mismatches;
    int pending;
    int burst_left;

    // Texels written so far; a shade only ever reads these
    bit loaded [0:TEX_DIM-1][0:TEX_DIM-1];

    sprite_texel_sample_alpha_blend DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .dest_pixel  (dest_pixel),
        .texel_col   (texel_col),
        .texel_row   (texel_row),
        .texel_value (texel_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_pixel   (out_pixel)
    );

    sprite_texel_sample_alpha_blend_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .dest_pixel  (dest_pixel),
        .texel_col   (texel_col),
        .texel_row   (texel_row),
        .texel_value (texel_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_pixel   (out_pixel),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one item and hold it until the transfer; close the burst with a gap
    task automatic push_item(
        input logic                   kind,
        input logic [PIXEL_W-1:0]     x,
        input logic [PIXEL_W-1:0]     y,
        input logic [WORD_W-1:0]      dest,
        input logic [TEXEL_IDX_W-1:0] col,
        input logic [TEXEL_IDX_W-1:0] row,
        input logic [WORD_W-1:0]      value
    );
        in_valid <= 1'b1;
        op <= kind;
        pixel_x <= x;
        pixel_y <= y;
        dest_pixel <= dest;
        texel_col <= col;
        texel_row <= row;
        texel_value <= value;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
        end
    endtask

    task automatic load_texel(
        input logic [TEXEL_IDX_W-1:0] col,
        input logic [TEXEL_IDX_W-1:0] row,
        input logic [WORD_W-1:0]      value
    );
        push_item(OP_LOAD, PIXEL_W'($urandom()), PIXEL_W'($urandom()), $urandom(),
                  col, row, value);
        loaded[row][col] = 1'b1;
    endtask

    task automatic shade(
        input logic [PIXEL_W-1:0] x,
        input logic [PIXEL_W-1:0] y,
        input logic [WORD_W-1:0]  dest
    );
        push_item(OP_SHADE, x, y, dest, TEXEL_IDX_W'($urandom()), TEXEL_IDX_W'($urandom()),
                  $urandom());
    endtask

    // Texel with alpha biased toward opaque, clear and near-edge values
    function automatic logic [WORD_W-1:0] make_texel();
        logic [WORD_W-1:0] t;
        int                r;
        t = $urandom();
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    t[31:24] = 8'd255;
            2:       t[31:24] = 8'd0;
            3:       t[31:24] = ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd254;
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return PIXEL_W'(PIXEL_MAX);
        return PIXEL_W'($urandom());
    endfunction

    // Size the block actually uses: zero acts as one, oversize as the full texture
    function automatic int eff_size(input logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > TEX_DIM)
            return TEX_DIM;
        return int'(s);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input bit big_ok);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (big_ok && r == 1)
            return SIZE_W'(TEX_DIM);
        if (big_ok && r == 2)
            return SIZE_W'($urandom_range(TEX_DIM + 1, (1 << SIZE_W) - 1));
        return SIZE_W'($urandom_range(1, 16));
    endfunction

    // Base that puts pixel zero somewhat left of, inside or past the texture
    function automatic logic [WORD_W-1:0] pick_base(input int span);
        return WORD_W'(int'($urandom_range(0, span * 3 / 2)) - span / 4);
    endfunction

    // Step that sweeps the texture across the coordinate range, mostly forward
    function automatic logic [WORD_W-1:0] pick_step(input int size);
        int s;
        s = int'($urandom_range(0, size * 48));
        return ($urandom_range(0, 3) == 0) ? WORD_W'(-s) : WORD_W'(s);
    endfunction

    // Drop valid and wait until every owed pixel is out and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(
        input logic [WORD_W-1:0] ub,
        input logic [WORD_W-1:0] us,
        input logic [WORD_W-1:0] vb,
        input logic [WORD_W-1:0] vs,
        input logic [SIZE_W-1:0] w,
        input logic [SIZE_W-1:0] h
    );
        settle();
        cfg_write(REG_U_BASE, ub);
        cfg_write(REG_U_STEP, us);
        cfg_write(REG_V_BASE, vb);
        cfg_write(REG_V_STEP, vs);
        // Junk above the size field must be dropped
        cfg_write(REG_TEX_WIDTH, {(WORD_W - SIZE_W)'($urandom()), w});
        cfg_write(REG_TEX_HEIGHT, {(WORD_W - SIZE_W)'($urandom()), h});
        cfg_we <= 1'b0;
    endtask

    // Load every texel a shade can reach under the current sizes
    task automatic fill_rect(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        for (int r = 0; r < eff_size(h); r++)
            for (int c = 0; c < eff_size(w); c++)
                if (!loaded[r][c])
                    load_texel(TEXEL_IDX_W'(c), TEXEL_IDX_W'(r), make_texel());
    endtask

    task automatic mixed_items(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 3)
                load_texel(TEXEL_IDX_W'($urandom()), TEXEL_IDX_W'($urandom()), make_texel());
            else
                shade(pick_coord(), pick_coord(), $urandom());
        end
    endtask

    task automatic run_phase(
        input logic [WORD_W-1:0] ub,
        input logic [WORD_W-1:0] us,
        input logic [WORD_W-1:0] vb,
        input logic [WORD_W-1:0] vs,
        input logic [SIZE_W-1:0] w,
        input logic [SIZE_W-1:0] h,
        input int                n
    );
        configure(ub, us, vb, vs, w, h);
        fill_rect(w, h);
        mixed_items(n);
    endtask

    task automatic random_phase(input int n);
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        w = pick_size(1'b1);
        h = pick_size(eff_size(w) <= 4);
        if ($urandom_range(0, 3) == 0)
            run_phase($urandom(), $urandom(), $urandom(), $urandom(), w, h, n);
        else
            run_phase(pick_base(eff_size(w) << 16), pick_step(eff_size(w)),
                      pick_base(eff_size(h) << 16), pick_step(eff_size(h)), w, h, n);
    endtask

    // Receiver: ready pattern changes per segment, with a long hold-off after 150 results and every 300 after that
    initial
    begin : receiver
        int mode;
        int seen;
        int next_hold;
        int cyc;
        seen = 0;
        next_hold = 150;
        cyc = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 120))
            begin
                @(posedge clk);
                cyc++;
                if (out_valid && out_ready)
                    seen++;
                // Hold off long enough for the pipe to fill and stall the input
                if (seen >= next_hold)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    next_hold += 300;
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((cyc % 8) < 3);
                endcase
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("[sprite_texel_sample_alpha_blend] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_U_BASE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        op <= OP_LOAD;
        pixel_x <= '0;
        pixel_y <= '0;
        dest_pixel <= '0;
        texel_col <= '0;
        texel_row <= '0;
        texel_value <= '0;
        burst_left = 20;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: every shade reads texel (0,0); sweep its alpha and the coordinates
        load_texel('0, '0, 32'hFF33_6699);
        shade('0, '0, 32'h1234_5678);
        shade(PIXEL_W'(PIXEL_MAX), PIXEL_W'(PIXEL_MAX), 32'hFFFF_FFFF);
        load_texel('0, '0, 32'h00FF_FFFF);
        shade('0, '0, 32'h0000_0000);
        shade(PIXEL_W'(17), PIXEL_W'(2000), 32'hFFFF_FFFF);
        load_texel('0, '0, 32'h80C0_4020);
        shade(PIXEL_W'(5), PIXEL_W'(5), 32'hA5A5_A5A5);
        load_texel('0, '0, 32'h01FF_FFFF);
        shade(PIXEL_W'(PIXEL_MAX), '0, 32'h0000_0000);
        load_texel('0, '0, 32'hFE00_0000);
        shade('0, PIXEL_W'(PIXEL_MAX), 32'hFFFF_FFFF);
        load_texel(TEXEL_IDX_W'(TEX_DIM - 1), TEXEL_IDX_W'(TEX_DIM - 1), 32'hFFFF_FFFF);
        load_texel(TEXEL_IDX_W'(TEX_DIM - 1), TEXEL_IDX_W'(TEX_DIM - 1), 32'h0000_0000);

        // Writes to indexes past the list must leave the registers alone
        settle();
        cfg_write(REG_SPARE_A, 32'hFFFF_FFFF);
        cfg_write(REG_SPARE_B, 32'h7FFF_0040);
        cfg_we <= 1'b0;
        shade(PIXEL_W'(1234), PIXEL_W'(321), 32'h5A5A_5A5A);
        shade(PIXEL_W'(PIXEL_MAX), PIXEL_W'(PIXEL_MAX), 32'hC3C3_C3C3);

        // Register extremes: oversize and zero sizes, full-scale base and step
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  SIZE_W'((1 << SIZE_W) - 1), '0, 60);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  '0, SIZE_W'(TEX_DIM), 60);

        // Full-width sweep: column advances once every 64 pixels
        run_phase(32'h0000_8000, 32'h0000_0400, 32'h0000_8000, 32'h0000_0080,
                  SIZE_W'(TEX_DIM), SIZE_W'(8), 120);

        repeat (12) random_phase(40);

        // Back to reset values
        run_phase('0, '0, '0, '0, SIZE_W'(1), SIZE_W'(1), 60);

        settle();
        if (mismatches == 0)
            $display("[sprite_texel_sample_alpha_blend] OK");
        else
            $display("[sprite_texel_sample_alpha_blend] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/stsab_pkg.sv
design/sprite_texel_sample_alpha_blend.sv
verif/sprite_texel_sample_alpha_blend_checker.sv
verif/sprite_texel_sample_alpha_blend_test.sv
